/* rtl/core/trapezoidal_speed_profile_assert.svh */
// ----------------------------------------------------------------------------
// trapezoidal_speed_profile_assert.svh
// assertion macros shared by the speed profile rtl
// ----------------------------------------------------------------------------
`ifndef TRAPEZOIDAL_SPEED_PROFILE_ASSERT_SVH
`define TRAPEZOIDAL_SPEED_PROFILE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsp same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define TSP_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsp next-cycle check failed");

`endif

/* rtl/core/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// tsp_pkg
// types, widths and helpers of the trapezoidal speed profile
// ----------------------------------------------------------------------------
package tsp_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DIST_W     = 25;
	localparam int SPD_W      = 20;
	localparam int TIME_W     = 24;
	localparam int OSPD_W     = 21;
	localparam int TRAV_W     = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_W      = 25;
	localparam int WIDE_W     = 48;
	localparam int DEN_W      = 21;
	localparam int REM_W      = 27;
	localparam int ROOT_W     = 24;
	localparam int CNT_W      = 6;
	localparam int DIV_STEPS  = 48;
	localparam int SQRT_STEPS = 24;
	localparam int MUL_A_W    = 32;
	localparam int MUL_B_W    = 24;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int DV_W       = 28;
	localparam int SPD_ACC_W  = 29;
	localparam int RD_W       = 36;
	localparam int DACC_W     = 40;

	localparam logic [SPD_W-1:0]  TOP_SPEED_RST = 20'd32768;
	localparam logic [SPD_W-1:0]  ACCEL_RST     = 20'd32768;
	localparam logic [WIDE_W-1:0] Q_LIMIT       = 48'h0000_4000_0000;

	typedef enum logic {
		OP_PLAN   = 1'b0,
		OP_SAMPLE = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOVE_DISTANCE = 3'd0,
		CFG_START_SPEED   = 3'd1,
		CFG_END_SPEED     = 3'd2,
		CFG_TOP_SPEED     = 3'd3,
		CFG_ACCELERATION  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEG_ACC,
		SEG_CRU,
		SEG_DEC,
		SEG_END
	} seg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_P_T0,
		ST_P_T4,
		ST_P_M0,
		ST_P_Q0,
		ST_P_M1,
		ST_P_Q1,
		ST_P_M2,
		ST_P_Q2,
		ST_P_CMP,
		ST_P_TH,
		ST_P_SQ,
		ST_P_TT,
		ST_P_F,
		ST_P_V,
		ST_P_A,
		ST_P_B,
		ST_P_C,
		ST_P_D,
		ST_S_SEG,
		ST_S_M1,
		ST_S_M2,
		ST_S_M3,
		ST_S_M4,
		ST_S_ADJ,
		ST_DIV,
		ST_OUT
	} state_t;

	function automatic logic [TIME_W-1:0] sat24(input logic [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] lim;
		lim = {{(WIDE_W-TIME_W){1'b0}}, {TIME_W{1'b1}}};
		return (v > lim) ? {TIME_W{1'b1}} : v[TIME_W-1:0];
	endfunction

endpackage

/* rtl/core/tsp_stream_if.sv */
// ----------------------------------------------------------------------------
// tsp_stream_if
// valid/ready channels carrying profile requests and profile results
// ----------------------------------------------------------------------------
interface tsp_in_if;
	logic                              valid;
	logic                              ready;
	logic                              operation;
	logic [tsp_pkg::TIME_W-1:0]        sample_time;

	modport source (output valid, output operation, output sample_time, input ready);
	modport sink   (input valid, input operation, input sample_time, output ready);
endinterface

interface tsp_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [tsp_pkg::OSPD_W-1:0] speed;
	logic [tsp_pkg::TRAV_W-1:0]        travelled;
	logic                              finished;
	logic [tsp_pkg::TIME_W-1:0]        total_time;

	modport source (output valid, output speed, output travelled, output finished,
		output total_time, input ready);
	modport sink   (input valid, input speed, input travelled, input finished,
		input total_time, output ready);
endinterface

/* rtl/core/trapezoidal_speed_profile.sv */
// ----------------------------------------------------------------------------
// trapezoidal_speed_profile
// trapezoidal / triangular speed profile planner and sampler, q.16 fixed point
// ----------------------------------------------------------------------------
// A plan transfer (operation 0) reads the move registers and works out the
// direction and the three segment end times; a sample transfer (operation 1)
// returns the signed speed and distance covered at sample_time, with a sticky
// finished flag once the end time is reached. Every transfer gives exactly one
// result. Work is done one item at a time by a small sequencer around one
// shift/subtract unit (restoring divide, one quotient bit a cycle, or integer
// square root, one root bit a cycle) and one 32x24 multiplier. A sample steps
// through ST_S_SEG, ST_S_M1 to ST_S_M3, ST_S_M4 (cruise) or ST_S_ADJ and ST_OUT,
// with two chained multiplier passes (three when cruising), or goes from
// ST_S_SEG to ST_OUT once the end time is passed. A plan runs eight 48-step
// divides, or six and one 24-step square root for a triangular move, in the
// shared unit. Input ready is high only while the sequencer is idle; a finished
// result sits in the output register, and the next item can be taken meanwhile.
// ----------------------------------------------------------------------------
`include "trapezoidal_speed_profile_assert.svh"

module trapezoidal_speed_profile (
	input  logic                            clk,
	input  logic                            arst_n,
	tsp_in_if.sink                          item,
	tsp_out_if.source                       result,
	input  logic                            cfg_we,
	input  logic [tsp_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tsp_pkg::CFG_W-1:0]       cfg_wdata
);

	localparam int FB = tsp_pkg::FRAC_BITS;
	localparam int WW = tsp_pkg::WIDE_W;

	// configuration registers
	logic [tsp_pkg::DIST_W-1:0] mdist_q;
	logic [tsp_pkg::SPD_W-1:0]  v0_q, v1_q, vtop_q, accel_q;

	// plan results kept between items
	logic [tsp_pkg::TIME_W-1:0] acc_end_q, dec_start_q, fin_q, dmag_q;
	logic                       dir_neg_q, done_q;

	// sequencer
	tsp_pkg::state_t state_q, state_d, ret_q, div_ret;
	tsp_pkg::seg_t   seg_q;
	logic            is_plan_q;

	// plan scratch
	logic [WW-1:0] t0_q, t4_q, dfull_q, cruise_q, mac_q, accw_q, tail_q, decw_q;

	// sample scratch
	logic [tsp_pkg::TIME_W-1:0]    t_q, tt_q;
	logic [tsp_pkg::SPD_W-1:0]     vsel_q;
	logic [tsp_pkg::DV_W-1:0]      dv_q;
	logic [tsp_pkg::SPD_ACC_W-1:0] spd_q;
	logic [tsp_pkg::DACC_W-1:0]    dist_q;

	// shared shift/subtract unit
	logic [WW-1:0]                 dq_q;
	logic [tsp_pkg::REM_W-1:0]     rem_q;
	logic [tsp_pkg::ROOT_W-1:0]    root_q;
	logic [tsp_pkg::DEN_W-1:0]     den_q;
	logic                          sqrt_q;
	logic [tsp_pkg::CNT_W-1:0]     cnt_q;
	logic [tsp_pkg::REM_W-1:0]     cand, trial, diff;
	logic                          ge;

	// shared multiplier
	logic [tsp_pkg::PROD_W-1:0]    prod_q;

	// control from the output decoder
	logic                          ready_c;
	logic                          div_start, div_sqrt;
	logic [WW-1:0]                 div_num;
	logic [tsp_pkg::DEN_W-1:0]     div_den;
	logic                          mul_en;
	logic [tsp_pkg::MUL_A_W-1:0]   mul_a;
	logic [tsp_pkg::MUL_B_W-1:0]   mul_b;

	// output register
	logic                              out_valid_q, out_fin_q, out_free, out_load;
	logic signed [tsp_pkg::OSPD_W-1:0] out_speed_q;
	logic [tsp_pkg::TRAV_W-1:0]        out_trav_q, out_total_q;

	// derived values
	logic [tsp_pkg::SPD_W-1:0]  a_eff, vmax_eff;
	logic [tsp_pkg::DIST_W-1:0] mag;
	logic [WW-1:0]              qclamp, fin_sum;
	logic [tsp_pkg::SPD_W-1:0]  spd_sat;
	logic                       fin_flag;
	logic                       xfer_in;

	// zero acceleration or top speed behaves as one lsb
	assign a_eff    = (accel_q == '0) ? tsp_pkg::SPD_W'(1) : accel_q;
	assign vmax_eff = (vtop_q == '0) ? tsp_pkg::SPD_W'(1) : vtop_q;
	// magnitude of the signed distance; full negative gives 2^24
	assign mag      = mdist_q[tsp_pkg::DIST_W-1] ? (~mdist_q + 1'b1) : mdist_q;
	assign qclamp   = (dq_q > tsp_pkg::Q_LIMIT) ? tsp_pkg::Q_LIMIT : dq_q;
	assign fin_sum  = decw_q + tail_q;
	assign spd_sat  = (spd_q > tsp_pkg::SPD_ACC_W'({tsp_pkg::SPD_W{1'b1}})) ?
		{tsp_pkg::SPD_W{1'b1}} : spd_q[tsp_pkg::SPD_W-1:0];
	assign fin_flag = done_q | (seg_q == tsp_pkg::SEG_END);
	assign xfer_in  = item.valid & ready_c;
	assign out_free = ~out_valid_q | result.ready;
	assign out_load = (state_q == tsp_pkg::ST_OUT) & out_free;

	// shared unit: divide brings in one dividend bit, root brings in two
	assign cand  = sqrt_q ? {rem_q[tsp_pkg::REM_W-3:0], dq_q[WW-1 -: 2]}
		: {rem_q[tsp_pkg::REM_W-2:0], dq_q[WW-1]};
	assign trial = sqrt_q ? {1'b0, root_q, 2'b01}
		: {{(tsp_pkg::REM_W-tsp_pkg::DEN_W){1'b0}}, den_q};
	assign ge    = (cand >= trial);
	assign diff  = cand - trial;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdist_q <= '0;
			v0_q    <= '0;
			v1_q    <= '0;
			vtop_q  <= tsp_pkg::TOP_SPEED_RST;
			accel_q <= tsp_pkg::ACCEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tsp_pkg::CFG_MOVE_DISTANCE: mdist_q <= cfg_wdata;
				tsp_pkg::CFG_START_SPEED:   v0_q    <= cfg_wdata[tsp_pkg::SPD_W-1:0];
				tsp_pkg::CFG_END_SPEED:     v1_q    <= cfg_wdata[tsp_pkg::SPD_W-1:0];
				tsp_pkg::CFG_TOP_SPEED:     vtop_q  <= cfg_wdata[tsp_pkg::SPD_W-1:0];
				tsp_pkg::CFG_ACCELERATION:  accel_q <= cfg_wdata[tsp_pkg::SPD_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsp_pkg::ST_IDLE: begin
				if (xfer_in) begin
					state_d = (item.operation == tsp_pkg::OP_PLAN) ?
						tsp_pkg::ST_P_T0 : tsp_pkg::ST_S_SEG;
				end
			end
			tsp_pkg::ST_P_M0:  state_d = tsp_pkg::ST_P_Q0;
			tsp_pkg::ST_P_M1:  state_d = tsp_pkg::ST_P_Q1;
			tsp_pkg::ST_P_M2:  state_d = tsp_pkg::ST_P_Q2;
			tsp_pkg::ST_P_CMP: begin
				state_d = (dfull_q < dq_q) ? tsp_pkg::ST_P_TH : tsp_pkg::ST_DIV;
			end
			tsp_pkg::ST_P_TH:  state_d = tsp_pkg::ST_P_SQ;
			tsp_pkg::ST_P_A:   state_d = tsp_pkg::ST_P_B;
			tsp_pkg::ST_P_B:   state_d = tsp_pkg::ST_P_C;
			tsp_pkg::ST_P_C:   state_d = tsp_pkg::ST_P_D;
			tsp_pkg::ST_P_D:   state_d = tsp_pkg::ST_OUT;
			tsp_pkg::ST_P_T0, tsp_pkg::ST_P_T4, tsp_pkg::ST_P_Q0, tsp_pkg::ST_P_Q1,
			tsp_pkg::ST_P_Q2, tsp_pkg::ST_P_SQ, tsp_pkg::ST_P_TT, tsp_pkg::ST_P_F,
			tsp_pkg::ST_P_V: state_d = tsp_pkg::ST_DIV;
			tsp_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ret_q;
				end
			end
			tsp_pkg::ST_S_SEG: begin
				// segment is being registered now, so decide from the times
				state_d = (t_q >= fin_q) ? tsp_pkg::ST_OUT : tsp_pkg::ST_S_M1;
			end
			tsp_pkg::ST_S_M1:  state_d = tsp_pkg::ST_S_M2;
			tsp_pkg::ST_S_M2:  state_d = tsp_pkg::ST_S_M3;
			tsp_pkg::ST_S_M3: begin
				state_d = (seg_q == tsp_pkg::SEG_CRU) ? tsp_pkg::ST_S_M4 : tsp_pkg::ST_S_ADJ;
			end
			tsp_pkg::ST_S_M4:  state_d = tsp_pkg::ST_OUT;
			tsp_pkg::ST_S_ADJ: state_d = tsp_pkg::ST_OUT;
			tsp_pkg::ST_OUT: begin
				if (out_free) begin
					state_d = tsp_pkg::ST_IDLE;
				end
			end
			default: state_d = tsp_pkg::ST_IDLE;
		endcase
	end

	// control outputs: unit launches and multiplier operands
	always_comb begin
		ready_c   = 1'b0;
		div_start = 1'b0;
		div_sqrt  = 1'b0;
		div_num   = '0;
		div_den   = {1'b0, a_eff};
		div_ret   = tsp_pkg::ST_IDLE;
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			tsp_pkg::ST_IDLE: ready_c = 1'b1;
			tsp_pkg::ST_P_T0: begin
				div_start = 1'b1;
				div_num   = WW'(v0_q) << FB;
				div_ret   = tsp_pkg::ST_P_T4;
			end
			tsp_pkg::ST_P_T4: begin
				div_start = 1'b1;
				div_num   = WW'(v1_q) << FB;
				div_ret   = tsp_pkg::ST_P_M0;
			end
			tsp_pkg::ST_P_M0: begin
				mul_en = 1'b1;
				mul_a  = tsp_pkg::MUL_A_W'(v0_q);
				mul_b  = tsp_pkg::MUL_B_W'(v0_q);
			end
			tsp_pkg::ST_P_Q0, tsp_pkg::ST_P_Q1: begin
				div_start = 1'b1;
				div_num   = prod_q[WW-1:0];
				div_den   = {a_eff, 1'b0};
				div_ret   = (state_q == tsp_pkg::ST_P_Q0) ? tsp_pkg::ST_P_M1 : tsp_pkg::ST_P_M2;
			end
			tsp_pkg::ST_P_M1: begin
				mul_en = 1'b1;
				mul_a  = tsp_pkg::MUL_A_W'(v1_q);
				mul_b  = tsp_pkg::MUL_B_W'(v1_q);
			end
			tsp_pkg::ST_P_M2: begin
				mul_en = 1'b1;
				mul_a  = tsp_pkg::MUL_A_W'(vmax_eff);
				mul_b  = tsp_pkg::MUL_B_W'(vmax_eff);
			end
			tsp_pkg::ST_P_Q2: begin
				div_start = 1'b1;
				div_num   = prod_q[WW-1:0];
				div_ret   = tsp_pkg::ST_P_CMP;
			end
			tsp_pkg::ST_P_CMP: begin
				// too short for top speed: peak speed from sqrt(a * dfull)
				if (dfull_q < dq_q) begin
					mul_en = 1'b1;
					mul_a  = tsp_pkg::MUL_A_W'(a_eff);
					mul_b  = dfull_q[tsp_pkg::MUL_B_W-1:0];
				end else begin
					div_start = 1'b1;
					div_num   = dfull_q - dq_q;
					div_den   = {1'b0, vmax_eff};
					div_ret   = tsp_pkg::ST_P_F;
				end
			end
			tsp_pkg::ST_P_TH: begin
				mul_en = 1'b1;
				mul_a  = tsp_pkg::MUL_A_W'(a_eff);
				mul_b  = dfull_q[WW-1 -: tsp_pkg::MUL_B_W];
			end
			tsp_pkg::ST_P_SQ: begin
				div_start = 1'b1;
				div_sqrt  = 1'b1;
				div_num   = mac_q + (prod_q[WW-1:0] << tsp_pkg::MUL_B_W);
				div_ret   = tsp_pkg::ST_P_TT;
			end
			tsp_pkg::ST_P_TT: begin
				div_start = 1'b1;
				div_num   = WW'(root_q) << FB;
				div_ret   = tsp_pkg::ST_P_A;
			end
			tsp_pkg::ST_P_F: begin
				div_start = 1'b1;
				div_num   = WW'(rem_q[tsp_pkg::DEN_W-1:0]) << FB;
				div_den   = {1'b0, vmax_eff};
				div_ret   = tsp_pkg::ST_P_V;
			end
			tsp_pkg::ST_P_V: begin
				div_start = 1'b1;
				div_num   = WW'(vmax_eff) << FB;
				div_ret   = tsp_pkg::ST_P_A;
			end
			tsp_pkg::ST_S_M1: begin
				mul_en = 1'b1;
				mul_a  = tsp_pkg::MUL_A_W'(a_eff);
				mul_b  = tt_q;
			end
			tsp_pkg::ST_S_M2: begin
				mul_en = 1'b1;
				mul_a  = tsp_pkg::MUL_A_W'({vsel_q, 1'b0})
					+ tsp_pkg::MUL_A_W'(prod_q[FB +: tsp_pkg::DV_W]);
				mul_b  = tt_q;
			end
			tsp_pkg::ST_S_M3: begin
				mul_en = (seg_q == tsp_pkg::SEG_CRU);
				mul_a  = tsp_pkg::MUL_A_W'(vmax_eff);
				mul_b  = t_q - acc_end_q;
			end
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsp_pkg::ST_IDLE;
			ret_q   <= tsp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
			if (div_start) begin
				ret_q <= div_ret;
			end
		end
	end

	// shared shift/subtract unit and multiplier
	always_ff @(posedge clk) begin
		if (div_start) begin
			dq_q   <= div_num;
			rem_q  <= '0;
			root_q <= '0;
			den_q  <= div_den;
			sqrt_q <= div_sqrt;
			cnt_q  <= div_sqrt ? tsp_pkg::CNT_W'(tsp_pkg::SQRT_STEPS - 1)
				: tsp_pkg::CNT_W'(tsp_pkg::DIV_STEPS - 1);
		end else if (state_q == tsp_pkg::ST_DIV) begin
			rem_q <= ge ? diff : cand;
			cnt_q <= cnt_q - 1'b1;
			if (sqrt_q) begin
				dq_q   <= dq_q << 2;
				root_q <= {root_q[tsp_pkg::ROOT_W-2:0], ge};
			end else begin
				dq_q <= {dq_q[WW-2:0], ge};
			end
		end
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// plan and sample datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			tsp_pkg::ST_IDLE: begin
				if (xfer_in) begin
					t_q       <= item.sample_time;
					is_plan_q <= (item.operation == tsp_pkg::OP_PLAN);
				end
			end
			tsp_pkg::ST_P_T4:  t0_q     <= dq_q;
			tsp_pkg::ST_P_M0:  t4_q     <= dq_q;
			tsp_pkg::ST_P_M1:  dfull_q  <= WW'(mag) + dq_q;
			tsp_pkg::ST_P_M2:  dfull_q  <= dfull_q + dq_q;
			tsp_pkg::ST_P_TH:  mac_q    <= prod_q[WW-1:0];
			tsp_pkg::ST_P_TT:  cruise_q <= '0;
			tsp_pkg::ST_P_F:   cruise_q <= qclamp << FB;
			tsp_pkg::ST_P_V:   cruise_q <= cruise_q + dq_q;
			// dq_q holds the full-speed ramp time from here on
			tsp_pkg::ST_P_A:   accw_q   <= (dq_q > t0_q) ? dq_q - t0_q : '0;
			tsp_pkg::ST_P_B:   tail_q   <= (dq_q > t4_q) ? dq_q - t4_q : '0;
			tsp_pkg::ST_P_C:   decw_q   <= accw_q + cruise_q;
			tsp_pkg::ST_S_SEG: begin
				if (t_q < acc_end_q) begin
					seg_q  <= tsp_pkg::SEG_ACC;
					tt_q   <= t_q;
					vsel_q <= v0_q;
				end else if (t_q < dec_start_q) begin
					seg_q  <= tsp_pkg::SEG_CRU;
					tt_q   <= acc_end_q;
					vsel_q <= v0_q;
				end else if (t_q < fin_q) begin
					seg_q  <= tsp_pkg::SEG_DEC;
					tt_q   <= fin_q - t_q;
					vsel_q <= v1_q;
				end else begin
					seg_q  <= tsp_pkg::SEG_END;
					spd_q  <= tsp_pkg::SPD_ACC_W'(v1_q);
					dist_q <= tsp_pkg::DACC_W'(dmag_q);
				end
			end
			tsp_pkg::ST_S_M2:  dv_q <= prod_q[FB +: tsp_pkg::DV_W];
			tsp_pkg::ST_S_M3: begin
				spd_q  <= (seg_q == tsp_pkg::SEG_CRU) ? tsp_pkg::SPD_ACC_W'(vmax_eff)
					: tsp_pkg::SPD_ACC_W'(vsel_q) + tsp_pkg::SPD_ACC_W'(dv_q);
				dist_q <= tsp_pkg::DACC_W'(prod_q[FB+1 +: tsp_pkg::RD_W]);
			end
			tsp_pkg::ST_S_M4: begin
				dist_q <= dist_q + tsp_pkg::DACC_W'(prod_q[FB +: tsp_pkg::DV_W]);
			end
			tsp_pkg::ST_S_ADJ: begin
				// deceleration distance counts back from the end point
				if (seg_q == tsp_pkg::SEG_DEC) begin
					dist_q <= (dist_q < tsp_pkg::DACC_W'(dmag_q)) ?
						tsp_pkg::DACC_W'(dmag_q) - dist_q : '0;
				end
			end
			default: ;
		endcase
	end

	// plan state kept across items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_end_q   <= '0;
			dec_start_q <= '0;
			fin_q       <= '0;
			dir_neg_q   <= 1'b0;
			dmag_q      <= '0;
			done_q      <= 1'b0;
		end else if (state_q == tsp_pkg::ST_P_D) begin
			acc_end_q   <= tsp_pkg::sat24(accw_q);
			dec_start_q <= tsp_pkg::sat24(decw_q);
			fin_q       <= tsp_pkg::sat24(fin_sum);
			dir_neg_q   <= mdist_q[tsp_pkg::DIST_W-1];
			dmag_q      <= tsp_pkg::sat24(WW'(mag));
			done_q      <= 1'b0;
		end else if (out_load && !is_plan_q) begin
			done_q <= fin_flag;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_total_q <= fin_q;
			if (is_plan_q) begin
				out_speed_q <= '0;
				out_trav_q  <= '0;
				out_fin_q   <= 1'b0;
			end else begin
				out_speed_q <= dir_neg_q ? -$signed({1'b0, spd_sat}) : $signed({1'b0, spd_sat});
				out_trav_q  <= tsp_pkg::sat24(WW'(dist_q));
				out_fin_q   <= fin_flag;
			end
		end
	end

	assign item.ready        = ready_c;
	assign result.valid      = out_valid_q;
	assign result.speed      = out_speed_q;
	assign result.travelled  = out_trav_q;
	assign result.finished   = out_fin_q;
	assign result.total_time = out_total_q;

	// a taken item always starts the sequencer
	`TSP_ASSERT_NXT(a_busy_after_xfer, item.valid && item.ready, state_q != tsp_pkg::ST_IDLE)
	// segment boundaries stay ordered
	`TSP_ASSERT_IMP(a_seg_order, 1'b1, acc_end_q <= dec_start_q && dec_start_q <= fin_q)
	// a reported finish is remembered until the next plan
	`TSP_ASSERT_IMP(a_fin_sticky, result.valid && result.finished && !is_plan_q, done_q)

endmodule
